### rtl/core/gbnsw_pkg.sv
// Shared widths, codes and the run descriptor of the go-back-n sender window.
`timescale 1ns / 1ps

package gbnsw_pkg;

  localparam int CMD_W      = 2;
  localparam int ACK_W      = 16;
  localparam int KIND_W     = 2;
  localparam int PIDX_W     = 12;
  localparam int SEQ_W      = 13;
  localparam int OFF_W      = 22;
  localparam int LEN_W      = 10;
  localparam int WS_W       = 5;
  localparam int DL_W       = 22;
  localparam int CFG_IDX_W  = 2;

  localparam int SEQ_BASE   = 511;

  // run descriptor fields are sized for the largest packet count and window
  localparam int RUN_IDX_W  = 16;
  localparam int RUN_CNT_W  = 7;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEND   = 2'd0,
    KIND_RESEND = 2'd1,
    KIND_DONE   = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_LIMIT   = 2'd0,
    REG_DATA_LENGTH = 2'd1
  } reg_e;

  // one run of consecutive packet commands caused by one event
  typedef struct packed {
    kind_e                kind;
    logic [RUN_IDX_W-1:0] first;
    logic [RUN_CNT_W-1:0] count;
    logic [RUN_IDX_W-1:0] last_idx;
  } run_t;

endpackage

### rtl/core/gbnsw_front.sv
// Event front end: window state, packet count divider and run classification.
`timescale 1ns / 1ps

module gbnsw_front #(
  parameter int MAX_PACKETS  = 4096,
  parameter int PACKET_BYTES = 1000,
  parameter int MAX_WINDOW   = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 command_i,
  input  logic [15:0]                ack_number_i,
  input  logic [4:0]                 win_limit_i,
  input  logic [21:0]                data_length_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output gbnsw_pkg::run_t            push_run_o
);
  import gbnsw_pkg::*;

  localparam int IDX_W  = $clog2(MAX_PACKETS + 1);
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = IDX_W + 8;
  // floor(x / PACKET_BYTES) equals (x * RECIP) >> DIV_SH for every DL_W-bit x
  localparam int DIV_SH = DL_W + $clog2(PACKET_BYTES);
  localparam int RCP_W  = DL_W + 2;
  localparam int PROD_W = DL_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << DIV_SH) + 64'(PACKET_BYTES) - 64'd1) / 64'(PACKET_BYTES));

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_START} fstate_e;

  fstate_e           state_q, state_d;
  logic [IDX_W-1:0]  base_q, base_d;
  logic [IDX_W-1:0]  next_q, next_d;
  logic [IDX_W-1:0]  total_q, total_d;
  logic              timer_q, timer_d;
  logic              done_q, done_d;
  logic [DL_W-1:0]   dq_q, dq_d;

  logic [WIN_W-1:0]  win;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  start_total;
  logic [WIN_W-1:0]  start_cnt;
  logic [IDX_W-1:0]  base_n;
  logic [SUM_W-1:0]  limit;
  logic [SUM_W-1:0]  end_idx;
  logic [WIN_W-1:0]  ack_cnt;
  logic              ack_match;
  logic              active;
  logic              in_ready;

  // clamp the configured window to 1..MAX_WINDOW
  always_comb begin
    if (win_limit_i == '0) begin
      win = WIN_W'(1);
    end else if (8'(win_limit_i) > 8'(MAX_WINDOW)) begin
      win = WIN_W'(MAX_WINDOW);
    end else begin
      win = WIN_W'(win_limit_i);
    end
  end

  // packet count quotient by reciprocal multiply, registered back into dq
  assign prod = PROD_W'(dq_q) * PROD_W'(RECIP);

  always_comb begin
    if (23'(dq_q) >= 23'(MAX_PACKETS)) begin
      start_total = IDX_W'(MAX_PACKETS);
    end else begin
      start_total = IDX_W'(dq_q + 1'b1);
    end
    if (SUM_W'(win) < SUM_W'(start_total)) begin
      start_cnt = win;
    end else begin
      start_cnt = WIN_W'(start_total);
    end
  end

  // window slide on a matching ack
  assign base_n    = base_q + 1'b1;
  assign limit     = SUM_W'(base_n) + SUM_W'(win);
  assign end_idx   = (limit < SUM_W'(total_q)) ? limit : SUM_W'(total_q);
  assign ack_cnt   = (end_idx > SUM_W'(next_q)) ? WIN_W'(end_idx - SUM_W'(next_q)) : '0;
  assign ack_match = ({1'b0, ack_number_i} == (17'(base_q) + 17'(SEQ_BASE)))
                     && (base_q != next_q);
  assign active    = (total_q != '0) && !done_q;

  assign in_ready   = (state_q == F_IDLE) && !q_full_i;
  assign in_ready_o = in_ready;

  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    next_d     = next_q;
    total_d    = total_q;
    timer_d    = timer_q;
    done_d     = done_q;
    dq_d       = dq_q;
    push_o     = 1'b0;
    push_run_o = '{kind: KIND_SEND, first: '0, count: '0,
                   last_idx: RUN_IDX_W'(total_q - 1'b1)};
    case (state_q)
      F_IDLE: begin
        if (in_valid_i && in_ready) begin
          case (cmd_e'(command_i))
            CMD_START: begin
              dq_d    = data_length_i;
              state_d = F_DIV;
            end
            CMD_ACK: begin
              if (active) begin
                if (ack_number_i == '0) begin
                  done_d     = 1'b1;
                  timer_d    = 1'b0;
                  push_o     = 1'b1;
                  push_run_o = '{kind: KIND_DONE, first: '0,
                                 count: RUN_CNT_W'(1), last_idx: '0};
                end else if (ack_match) begin
                  base_d = base_n;
                  next_d = next_q + IDX_W'(ack_cnt);
                  if (ack_cnt != '0) begin
                    push_o           = 1'b1;
                    push_run_o.first = RUN_IDX_W'(next_q);
                    push_run_o.count = RUN_CNT_W'(ack_cnt);
                    if (base_n == next_q) begin
                      timer_d = 1'b1;
                    end
                  end
                end
              end
            end
            CMD_TIMEOUT: begin
              if (active && timer_q && (next_q != base_q)) begin
                push_o           = 1'b1;
                push_run_o.kind  = KIND_RESEND;
                push_run_o.first = RUN_IDX_W'(base_q);
                push_run_o.count = RUN_CNT_W'(next_q - base_q);
              end
            end
            default: ;
          endcase
        end
      end
      F_DIV: begin
        dq_d    = DL_W'(prod >> DIV_SH);
        state_d = F_START;
      end
      F_START: begin
        // first window always holds at least one packet, so the timer arms
        total_d    = start_total;
        base_d     = '0;
        next_d     = IDX_W'(start_cnt);
        timer_d    = 1'b1;
        done_d     = 1'b0;
        push_o     = 1'b1;
        push_run_o = '{kind: KIND_SEND, first: '0, count: RUN_CNT_W'(start_cnt),
                       last_idx: RUN_IDX_W'(start_total - 1'b1)};
        state_d    = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      base_q  <= '0;
      next_q  <= '0;
      total_q <= '0;
      timer_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      next_q  <= next_d;
      total_q <= total_d;
      timer_q <= timer_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q <= dq_d;
  end

endmodule

### rtl/core/gbnsw_queue.sv
// Two-entry run queue between the event front end and the command back end.
`timescale 1ns / 1ps

module gbnsw_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gbnsw_pkg::run_t push_run_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output gbnsw_pkg::run_t run_o
);
  import gbnsw_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  run_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign run_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_run_i;
    end
  end

endmodule

### rtl/core/gbnsw_back.sv
// Command back end: expands each run into packet commands on the output register.
`timescale 1ns / 1ps

module gbnsw_back #(
  parameter int MAX_PACKETS  = 4096,
  parameter int PACKET_BYTES = 1000,
  parameter int MAX_WINDOW   = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  gbnsw_pkg::run_t run_i,
  output logic            pop_o,
  input  logic [21:0]     data_length_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      kind_o,
  output logic [11:0]     packet_index_o,
  output logic [12:0]     seq_number_o,
  output logic [21:0]     byte_offset_o,
  output logic [9:0]      byte_length_o,
  output logic            last_of_run_o
);
  import gbnsw_pkg::*;

  localparam int IDX_W  = $clog2(MAX_PACKETS + 1);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int OFFX_W = $clog2(MAX_PACKETS * PACKET_BYTES + 1);
  localparam int CMP_W  = (OFFX_W > DL_W) ? OFFX_W : DL_W;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_EMIT} bstate_e;

  bstate_e           state_q, state_d;
  kind_e             kind_q, kind_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  last_q, last_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CMP_W-1:0]  off_q, off_d;
  logic              ov_q, ov_d;
  logic [KIND_W-1:0] okind_q, okind_d;
  logic [PIDX_W-1:0] oidx_q, oidx_d;
  logic [SEQ_W-1:0]  oseq_q, oseq_d;
  logic [OFF_W-1:0]  ooff_q, ooff_d;
  logic [LEN_W-1:0]  olen_q, olen_d;
  logic              olast_q, olast_d;

  logic              load_ok;
  logic              is_last_pkt;
  logic [31:0]       idx32, seq32, off32;
  logic [CMP_W-1:0]  dl_x, diff;
  logic [LEN_W-1:0]  len;

  assign load_ok     = !ov_q || out_ready_i;
  assign is_last_pkt = (idx_q == last_q);
  assign idx32       = 32'(idx_q);
  assign seq32       = idx32 + 32'(SEQ_BASE);
  assign off32       = 32'(off_q);
  assign dl_x        = CMP_W'(data_length_i);
  assign diff        = dl_x - off_q;

  // last packet carries the remainder of the file, capped at one packet
  always_comb begin
    if (!is_last_pkt) begin
      len = LEN_W'(PACKET_BYTES);
    end else if (dl_x > off_q) begin
      len = (diff > CMP_W'(PACKET_BYTES)) ? LEN_W'(PACKET_BYTES) : LEN_W'(diff);
    end else begin
      len = '0;
    end
  end

  assign pop_o = (state_q == B_IDLE) && q_valid_i;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    idx_d   = idx_q;
    last_d  = last_q;
    rem_d   = rem_q;
    off_d   = off_q;
    ov_d    = ov_q && !out_ready_i;
    okind_d = okind_q;
    oidx_d  = oidx_q;
    oseq_d  = oseq_q;
    ooff_d  = ooff_q;
    olen_d  = olen_q;
    olast_d = olast_q;
    case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          kind_d  = run_i.kind;
          idx_d   = IDX_W'(run_i.first);
          rem_d   = CNT_W'(run_i.count);
          last_d  = IDX_W'(run_i.last_idx);
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        off_d   = CMP_W'(idx_q) * CMP_W'(PACKET_BYTES);
        state_d = B_EMIT;
      end
      B_EMIT: begin
        // hold until the output register is free
        if (load_ok) begin
          ov_d    = 1'b1;
          okind_d = kind_q;
          olast_d = (rem_q == CNT_W'(1));
          if (kind_q == KIND_DONE) begin
            oidx_d = '0;
            oseq_d = '0;
            ooff_d = '0;
            olen_d = '0;
          end else begin
            oidx_d = idx32[PIDX_W-1:0];
            oseq_d = is_last_pkt ? '0 : seq32[SEQ_W-1:0];
            ooff_d = off32[OFF_W-1:0];
            olen_d = len;
          end
          idx_d   = idx_q + 1'b1;
          rem_d   = rem_q - 1'b1;
          state_d = (rem_q == CNT_W'(1)) ? B_IDLE : B_MUL;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ov_q    <= 1'b0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    idx_q   <= idx_d;
    last_q  <= last_d;
    off_q   <= off_d;
    okind_q <= okind_d;
    oidx_q  <= oidx_d;
    oseq_q  <= oseq_d;
    ooff_q  <= ooff_d;
    olen_q  <= olen_d;
    olast_q <= olast_d;
  end

  assign out_valid_o    = ov_q;
  assign kind_o         = okind_q;
  assign packet_index_o = oidx_q;
  assign seq_number_o   = oseq_q;
  assign byte_offset_o  = ooff_q;
  assign byte_length_o  = olen_q;
  assign last_of_run_o  = olast_q;

endmodule

### rtl/core/go_back_n_sender_window_top.sv
// Go-back-n sender window controller: config registers, front end, run queue, back end.
//
// Events enter on the in_ channel (command_i, ack_number_i); packet commands
// leave on the out_ channel, one transfer per command, last_of_run_o marking
// the final command of one event. The cfg_ channel writes the window limit
// (index 0) and data_length (index 1); cfg_ready_o is always high. Write it
// only while no event is in flight.
// An ack or timeout is classified and queued in the cycle it is accepted. A
// start takes the packet count from a reciprocal multiply in F_DIV and sets up
// the new window in F_START; in_ready_o stays low through both states, and
// its run is queued from F_START. The back end pops a run in B_IDLE, then for
// each command passes B_MUL (offset multiply) and B_EMIT (the output register
// load, which waits while the output register is still held).
// A two-entry run queue sits between the two halves; when the receiver
// stalls, the output register holds, the queue fills and in_ready_o drops.
// Reset clears the window state (no transfer), the window limit to 4 and
// data_length to 0.
`timescale 1ns / 1ps

module go_back_n_sender_window_top #(
  parameter int MAX_PACKETS  = 4096,
  parameter int PACKET_BYTES = 1000,
  parameter int MAX_WINDOW   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [21:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] ack_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [11:0] packet_index_o,
  output logic [12:0] seq_number_o,
  output logic [21:0] byte_offset_o,
  output logic [9:0]  byte_length_o,
  output logic        last_of_run_o
);
  import gbnsw_pkg::*;

  logic [WS_W-1:0] win_limit_q;
  logic [DL_W-1:0] data_length_q;
  logic            q_full, q_valid, push, pop;
  run_t            push_run, head_run;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_limit_q   <= WS_W'(4);
      data_length_q <= '0;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_WIN_LIMIT:   win_limit_q   <= cfg_data_i[WS_W-1:0];
        REG_DATA_LENGTH: data_length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gbnsw_front #(
    .MAX_PACKETS  (MAX_PACKETS),
    .PACKET_BYTES (PACKET_BYTES),
    .MAX_WINDOW   (MAX_WINDOW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .ack_number_i  (ack_number_i),
    .win_limit_i   (win_limit_q),
    .data_length_i (data_length_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_run_o    (push_run)
  );

  gbnsw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_run_i (push_run),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .run_o      (head_run)
  );

  gbnsw_back #(
    .MAX_PACKETS  (MAX_PACKETS),
    .PACKET_BYTES (PACKET_BYTES),
    .MAX_WINDOW   (MAX_WINDOW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .run_i          (head_run),
    .pop_o          (pop),
    .data_length_i  (data_length_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .packet_index_o (packet_index_o),
    .seq_number_o   (seq_number_o),
    .byte_offset_o  (byte_offset_o),
    .byte_length_o  (byte_length_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

### rtl/core/gbnsw_checker.sv
// Port-level checks for the go-back-n sender window, bound to the top level.
`timescale 1ns / 1ps

module gbnsw_checker #(
  parameter int PACKET_BYTES = 1000
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  command_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [11:0] packet_index_o,
  input logic [12:0] seq_number_o,
  input logic [21:0] byte_offset_o,
  input logic [9:0]  byte_length_o,
  input logic        last_of_run_o
);
  import gbnsw_pkg::*;

  // a stalled command stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o
      && $stable({kind_o, packet_index_o, seq_number_o, byte_offset_o,
                  byte_length_o, last_of_run_o}))
    else $error("output transfer changed while stalled");

  // completion is a lone, empty command
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_DONE) |-> (packet_index_o == '0)
      && (seq_number_o == '0) && (byte_offset_o == '0)
      && (byte_length_o == '0) && last_of_run_o)
    else $error("completion command carries packet fields");

  // only the last packet may be short
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_DONE) && (seq_number_o != '0)
      |-> (byte_length_o == LEN_W'(PACKET_BYTES)))
    else $error("short payload on a packet that is not the last");

  // a start keeps the input side busy while the packet count is worked out
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i == CMD_START) |=> !in_ready_o)
    else $error("input ready right after a start");

endmodule

bind go_back_n_sender_window_top gbnsw_checker #(.PACKET_BYTES(PACKET_BYTES)) u_gbnsw_checker (.*);

### verif/gbnsw_checker.sv
// Scoreboard for the go-back-n sender window: predicts packet commands and checks the output.
`timescale 1ns / 1ps

module gbnsw_scoreboard #(
  parameter int MAX_PACKETS  = 4096,
  parameter int PACKET_BYTES = 1000,
  parameter int MAX_WINDOW   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [gbnsw_pkg::DL_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [gbnsw_pkg::CMD_W-1:0]  command_i,
  input  logic [gbnsw_pkg::ACK_W-1:0]  ack_number_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [gbnsw_pkg::KIND_W-1:0] kind_i,
  input  logic [gbnsw_pkg::PIDX_W-1:0] packet_index_i,
  input  logic [gbnsw_pkg::SEQ_W-1:0]  seq_number_i,
  input  logic [gbnsw_pkg::OFF_W-1:0]  byte_offset_i,
  input  logic [gbnsw_pkg::LEN_W-1:0]  byte_length_i,
  input  logic                         last_of_run_i,
  output int                           mismatch_count_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           events_o
);
  import gbnsw_pkg::*;

  typedef struct {
    kind_e             kind;
    logic [PIDX_W-1:0] index;
    logic [SEQ_W-1:0]  seq;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
    logic              last;
  } pkt_cmd_t;

  pkt_cmd_t        pkt_cmd_q[$];

  logic [WS_W-1:0] win_reg;
  logic [DL_W-1:0] len_reg;
  logic [12:0]     base_idx;
  logic [12:0]     next_idx;
  logic [12:0]     total_pkts;
  bit              armed;
  bit              done;
  int              mismatches;
  int              checked;
  int              events;

  function automatic pkt_cmd_t packet_cmd(input kind_e kind, input logic [12:0] idx);
    pkt_cmd_t    c;
    int unsigned off;
    int unsigned len;
    off      = int'(idx) * PACKET_BYTES;
    len      = PACKET_BYTES;
    c.kind   = kind;
    c.index  = idx[PIDX_W-1:0];
    c.seq    = SEQ_W'(SEQ_BASE + idx);
    if (int'(idx) + 1 == int'(total_pkts)) begin
      // last packet carries the remainder of the file
      c.seq = '0;
      len   = (int'(len_reg) > off) ? int'(len_reg) - off : 0;
      if (len > PACKET_BYTES) len = PACKET_BYTES;
    end
    c.offset = off[OFF_W-1:0];
    c.length = len[LEN_W-1:0];
    c.last   = 1'b0;
    return c;
  endfunction

  task automatic fill_window();
    int unsigned win;
    int unsigned limit;
    win   = (win_reg == 0) ? 1 : (win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg;
    limit = int'(base_idx) + win;
    while (next_idx < limit && next_idx < total_pkts) begin
      if (base_idx == next_idx) armed = 1'b1;
      pkt_cmd_q.push_back(packet_cmd(KIND_SEND, next_idx));
      next_idx++;
    end
  endtask

  always @(posedge clk_i) begin
    int          n_before;
    int unsigned cnt;
    logic [12:0] i;
    pkt_cmd_t    exp_c;
    if (!rst_ni) begin
      win_reg    = 5'd4;
      len_reg    = '0;
      base_idx   = '0;
      next_idx   = '0;
      total_pkts = '0;
      armed      = 1'b0;
      done       = 1'b0;
      mismatches = 0;
      checked    = 0;
      events     = 0;
      pkt_cmd_q.delete();
    end else begin
      // outputs belong to earlier events, so check before predicting new ones
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (pkt_cmd_q.size() == 0) begin
          if (mismatches < 10)
            $display("chk: unexpected command kind %0d idx %0d seq %0d off %0d len %0d last %0b",
                     kind_i, packet_index_i, seq_number_i, byte_offset_i, byte_length_i,
                     last_of_run_i);
          mismatches++;
        end else begin
          exp_c = pkt_cmd_q.pop_front();
          if (kind_i !== exp_c.kind || packet_index_i !== exp_c.index ||
              seq_number_i !== exp_c.seq || byte_offset_i !== exp_c.offset ||
              byte_length_i !== exp_c.length || last_of_run_i !== exp_c.last) begin
            if (mismatches < 10)
              $display({"chk: command %0d: expected kind %0d idx %0d seq %0d off %0d len %0d ",
                        "last %0b, got kind %0d idx %0d seq %0d off %0d len %0d last %0b"},
                       checked, exp_c.kind, exp_c.index, exp_c.seq, exp_c.offset,
                       exp_c.length, exp_c.last, kind_i, packet_index_i, seq_number_i,
                       byte_offset_i, byte_length_i, last_of_run_i);
            mismatches++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_WIN_LIMIT:   win_reg = cfg_data_i[WS_W-1:0];
          REG_DATA_LENGTH: len_reg = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        events++;
        n_before = pkt_cmd_q.size();
        if (command_i == CMD_START) begin
          cnt = len_reg / PACKET_BYTES + 1;
          if (cnt > MAX_PACKETS) cnt = MAX_PACKETS;
          total_pkts = cnt[12:0];
          base_idx   = '0;
          next_idx   = '0;
          armed      = 1'b0;
          done       = 1'b0;
          fill_window();
        end else if (total_pkts == 0 || done) begin
          // drop: no transfer in progress
        end else if (command_i == CMD_ACK) begin
          if (ack_number_i == 0) begin
            armed        = 1'b0;
            done         = 1'b1;
            exp_c.kind   = KIND_DONE;
            exp_c.index  = '0;
            exp_c.seq    = '0;
            exp_c.offset = '0;
            exp_c.length = '0;
            exp_c.last   = 1'b0;
            pkt_cmd_q.push_back(exp_c);
          end else if (ack_number_i == int'(base_idx) + SEQ_BASE && base_idx < next_idx) begin
            base_idx++;
            fill_window();
          end
        end else if (command_i == CMD_TIMEOUT) begin
          if (armed)
            for (i = base_idx; i < next_idx; i++)
              pkt_cmd_q.push_back(packet_cmd(KIND_RESEND, i));
        end
        if (pkt_cmd_q.size() > n_before) begin
          exp_c      = pkt_cmd_q.pop_back();
          exp_c.last = 1'b1;
          pkt_cmd_q.push_back(exp_c);
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= pkt_cmd_q.size();
    checked_o        <= checked;
    events_o         <= events;
  end

endmodule

### verif/tb.sv
// Stimulus and verdict for the go-back-n sender window, with the checker beside the block.
`timescale 1ns / 1ps

module tb;
  import gbnsw_pkg::*;

  localparam int LIMIT        = 3_000_000;
  localparam int DRAIN        = 48;
  localparam int RANDOM_ITEMS = 235;
  localparam int PACKET_BYTES = 1000;
  localparam int MAX_PACKETS  = 4096;

  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              cfg_valid   = 1'b0;
  logic [1:0]        cfg_index   = REG_WIN_LIMIT;
  logic [DL_W-1:0]   cfg_data    = '0;
  logic              in_valid    = 1'b0;
  logic [CMD_W-1:0]  command     = CMD_START;
  logic [ACK_W-1:0]  ack_number  = '0;
  logic              out_ready   = 1'b0;
  logic              cfg_ready;
  logic              in_ready;
  logic              out_valid;
  logic [KIND_W-1:0] kind;
  logic [PIDX_W-1:0] packet_index;
  logic [SEQ_W-1:0]  seq_number;
  logic [OFF_W-1:0]  byte_offset;
  logic [LEN_W-1:0]  byte_length;
  logic              last_of_run;

  int                mismatches;
  int                pending;
  int                checked;
  int                events;

  int unsigned       cycles    = 0;
  bit                calm      = 1'b0;
  int                hold_left = 0;

  // stimulus-side view of the transfer, used only to aim acknowledgements
  int                aim_base;
  int                aim_total;
  logic [DL_W-1:0]   cur_dl;
  int                phases;

  go_back_n_sender_window_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .ack_number_i   (ack_number),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .packet_index_o (packet_index),
    .seq_number_o   (seq_number),
    .byte_offset_o  (byte_offset),
    .byte_length_o  (byte_length),
    .last_of_run_o  (last_of_run)
  );

  gbnsw_scoreboard chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .command_i        (command),
    .ack_number_i     (ack_number),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .kind_i           (kind),
    .packet_index_i   (packet_index),
    .seq_number_i     (seq_number),
    .byte_offset_i    (byte_offset),
    .byte_length_i    (byte_length),
    .last_of_run_i    (last_of_run),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .checked_o        (checked),
    .events_o         (events)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // cycle limit and stretches without any idling
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 600 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (cycles >= LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d commands still expected", cycles, pending);
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (calm || $urandom_range(0, 2) != 0) begin
      out_ready <= 1'b1;
      hold_left <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b0;
      hold_left <= pick_gap();
    end
  end

  task automatic push_event(input logic [CMD_W-1:0] cmd, input logic [ACK_W-1:0] ack);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    ack_number <= ack;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_config(input logic [WS_W-1:0] ws, input logic [DL_W-1:0] dl);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WIN_LIMIT;
    cfg_data  <= DL_W'(ws);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_DATA_LENGTH;
    cfg_data  <= dl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_dl = dl;
    phases++;
  endtask

  // hold off until every command is out and the front end has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic start_transfer();
    push_event(CMD_START, 16'($urandom));
    aim_base  = 0;
    aim_total = cur_dl / PACKET_BYTES + 1;
    if (aim_total > MAX_PACKETS) aim_total = MAX_PACKETS;
  endtask

  task automatic good_ack();
    push_event(CMD_ACK, 16'(SEQ_BASE + aim_base));
    if (aim_base < aim_total) aim_base++;
  endtask

  initial begin
    int              events_at_random;
    int              n_ev;
    int              r;
    bit              finished;
    logic [WS_W-1:0] ws;
    logic [DL_W-1:0] dl;

    cur_dl   = '0;
    phases   = 0;
    aim_base = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings: window 4, empty file; events before any start are dropped
    push_event(CMD_ACK, 16'd511);
    push_event(CMD_TIMEOUT, 16'd0);
    push_event(CMD_RESERVED, 16'hFFFF);
    start_transfer();                    // single packet of length 0
    push_event(CMD_TIMEOUT, 16'h0000);   // resend it
    good_ack();                          // window empties
    push_event(CMD_TIMEOUT, 16'h5555);   // armed, nothing in flight
    push_event(CMD_ACK, 16'd0);          // final ack
    push_event(CMD_ACK, 16'd511);        // dropped after completion
    settle();

    // window above range, file larger than the packet count allows
    write_config(5'd31, 22'h3FFFFF);
    start_transfer();
    push_event(CMD_TIMEOUT, 16'hAAAA);
    push_event(CMD_ACK, 16'd512);        // ahead of the window base
    good_ack();
    push_event(CMD_RESERVED, 16'd0);
    settle();

    // window 0 acts as 1, file an exact multiple of the packet size
    write_config(5'd0, 22'd3000);
    start_transfer();
    good_ack();
    good_ack();
    push_event(CMD_ACK, 16'd512);        // duplicate
    good_ack();
    push_event(CMD_TIMEOUT, 16'd1);
    good_ack();
    push_event(CMD_ACK, 16'd0);
    settle();

    // restart in the middle of a transfer
    write_config(5'd16, 22'd999);
    start_transfer();
    start_transfer();
    push_event(CMD_ACK, 16'd0);
    settle();

    events_at_random = events;
    while (events - events_at_random < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10)      ws = 5'd0;
      else if (r < 20) ws = 5'($urandom_range(17, 31));
      else if (r < 30) ws = 5'd16;
      else             ws = 5'($urandom_range(1, 16));
      r = $urandom_range(0, 99);
      if (r < 8)       dl = 22'($urandom_range(4_000_000, 4_194_303));
      else if (r < 18) dl = 22'($urandom_range(0, 30) * PACKET_BYTES);
      else             dl = 22'($urandom_range(0, 30_000));
      write_config(ws, dl);

      start_transfer();
      n_ev     = $urandom_range(3, 30);
      finished = 1'b0;
      for (int k = 0; k < n_ev && !finished; k++) begin
        r = $urandom_range(0, 99);
        if (r < 62) begin
          if (aim_base >= aim_total) begin
            push_event(CMD_ACK, 16'd0);
            finished = 1'b1;
          end else begin
            good_ack();
          end
        end else if (r < 72) begin
          push_event(CMD_TIMEOUT, 16'($urandom));
        end else if (r < 79) begin
          push_event(CMD_ACK, 16'($urandom_range(1, 65535)));
        end else if (r < 83) begin
          push_event(CMD_RESERVED, 16'($urandom));
        end else if (r < 87) begin
          // early final ack, then one that must be dropped
          push_event(CMD_ACK, 16'd0);
          push_event(CMD_ACK, 16'(SEQ_BASE + aim_base));
          finished = 1'b1;
        end else if (r < 92) begin
          start_transfer();
        end else if (r < 96) begin
          push_event(CMD_ACK, 16'(SEQ_BASE + aim_base + 1 + $urandom_range(0, 16)));
        end else begin
          push_event(CMD_ACK, 16'(SEQ_BASE + aim_base - 1));
        end
      end
      if (!finished) push_event(CMD_ACK, 16'd0);
      settle();
    end

    $display("tb: %0d events over %0d register settings, %0d packet commands checked",
             events, phases, checked);
    $display("tb: covered window 0..31, empty, exact-multiple and oversized files, %0d errors",
             mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/gbnsw_pkg.sv
rtl/core/gbnsw_front.sv
rtl/core/gbnsw_queue.sv
rtl/core/gbnsw_back.sv
rtl/core/go_back_n_sender_window_top.sv
rtl/core/gbnsw_checker.sv
verif/gbnsw_checker.sv
verif/tb.sv
